### rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// shared types and constants for the toroidal diffusion stencil
// ----------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

  localparam int IN_COORD_W  = 7;
  localparam int OUT_COORD_W = 7;
  localparam int COORD_W     = 8;   // wrapped coordinates stay below 255
  localparam int LEVEL_W     = 16;
  localparam int RATE_W      = 16;
  localparam int SUM_W       = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_W       = 8;

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGROWTH_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUTRIENT_MAX   = 3'd4;

  // floor(n / 9) == (n * RECIP_NINE) >> RECIP_SHIFT for every n below 2**21
  localparam int                RECIP_SHIFT = 23;
  localparam logic [SUM_W-1:0]  RECIP_NINE  = 20'd932068;

  localparam int NBR_COUNT = 9;
  localparam int NBR_IDX_W = 4;

  localparam logic [1:0] SEL_MID = 2'd0;
  localparam logic [1:0] SEL_LO  = 2'd1;
  localparam logic [1:0] SEL_HI  = 2'd2;

  // read order of the neighbourhood, centre first
  localparam logic [1:0] NBR_XSEL [0:NBR_COUNT-1] = '{
    SEL_MID, SEL_LO, SEL_HI, SEL_MID, SEL_MID, SEL_LO, SEL_HI, SEL_LO, SEL_HI
  };
  localparam logic [1:0] NBR_YSEL [0:NBR_COUNT-1] = '{
    SEL_MID, SEL_MID, SEL_MID, SEL_LO, SEL_HI, SEL_LO, SEL_LO, SEL_HI, SEL_HI
  };

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] yu;
    logic [COORD_W-1:0] yd;
    logic [LEVEL_W-1:0] level;
  } item_t;

endpackage

`default_nettype wire

### rtl/toroidal_diffusion_stencil_core.sv
// ----------------------------------------------------------------------------
// toroidal_diffusion_stencil_core
// wrap-around nutrient grid with 3x3 box-filter diffusion and regrowth
//
//   channel  handshake       payload
//   input    push / full     in_command, in_cell_x, in_cell_y, in_level_in
//   result   empty / pop     out_x, out_y, out_level_out
//   config   cfg_we          cfg_index, cfg_data
//
// the front takes an item, then wraps its coordinates one remainder bit per
// cycle and takes no new item meanwhile. the back writes a store from the
// queue and reads a compute's nine cells through the single grid ram port.
// reset sets the config registers and empties the queue and result beat;
// the grid is not cleared. a waiting result beat holds the back end, and the
// front stalls once the two-entry queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_diffusion_stencil_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_command,
  input  logic [tds_pkg::IN_COORD_W-1:0]   in_cell_x,
  input  logic [tds_pkg::IN_COORD_W-1:0]   in_cell_y,
  input  logic [tds_pkg::LEVEL_W-1:0]      in_level_in,
  output logic                             empty,
  input  logic                             pop,
  output logic [tds_pkg::OUT_COORD_W-1:0]  out_x,
  output logic [tds_pkg::OUT_COORD_W-1:0]  out_y,
  output logic [tds_pkg::LEVEL_W-1:0]      out_level_out,
  input  logic                             cfg_we,
  input  logic [tds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [tds_pkg::DIM_W-1:0]   grid_width_r, grid_height_r;
  logic [tds_pkg::RATE_W-1:0]  diffusion_rate_r, regrowth_rate_r;
  logic [tds_pkg::LEVEL_W-1:0] nutrient_max_r;
  logic [tds_pkg::DIM_W-1:0]   eff_w, eff_h;

  logic                        q_push, q_full, q_pop, q_empty;
  tds_pkg::item_t              q_wr_item, q_rd_item;

  logic                        ram_en, ram_we;
  logic [ADDR_W-1:0]           ram_addr;
  logic [tds_pkg::LEVEL_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= 8'd128;
      grid_height_r    <= 8'd128;
      diffusion_rate_r <= 16'd16384;
      regrowth_rate_r  <= 16'd0;
      nutrient_max_r   <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        tds_pkg::REG_GRID_WIDTH:     grid_width_r     <= cfg_data[tds_pkg::DIM_W-1:0];
        tds_pkg::REG_GRID_HEIGHT:    grid_height_r    <= cfg_data[tds_pkg::DIM_W-1:0];
        tds_pkg::REG_DIFFUSION_RATE: diffusion_rate_r <= cfg_data;
        tds_pkg::REG_REGROWTH_RATE:  regrowth_rate_r  <= cfg_data;
        tds_pkg::REG_NUTRIENT_MAX:   nutrient_max_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero means one, anything past the grid saturates
  always_comb begin
    if (grid_width_r == '0) begin
      eff_w = 8'd1;
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      eff_w = 8'(MAX_WIDTH);
    end else begin
      eff_w = grid_width_r;
    end
    if (grid_height_r == '0) begin
      eff_h = 8'd1;
    end else if (32'(grid_height_r) > MAX_HEIGHT) begin
      eff_h = 8'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height_r;
    end
  end

  tds_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_command  (in_command),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_level_in (in_level_in),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .q_push      (q_push),
    .q_item      (q_wr_item),
    .q_full      (q_full)
  );

  tds_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  tds_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (q_rd_item),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .diffusion_rate (diffusion_rate_r),
    .regrowth_rate  (regrowth_rate_r),
    .nutrient_max   (nutrient_max_r),
    .ram_en         (ram_en),
    .ram_we         (ram_we),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata),
    .out_empty      (empty),
    .out_pop        (pop),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_level      (out_level_out)
  );

  tds_ram #(
    .WIDTH  (tds_pkg::LEVEL_W),
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/tds_ram.sv
// ----------------------------------------------------------------------------
// tds_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tds_front.sv
// ----------------------------------------------------------------------------
// tds_front
// accepts items, wraps coordinates and works out the toroidal neighbours
// ----------------------------------------------------------------------------
`default_nettype none

module tds_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_command,
  input  logic [tds_pkg::IN_COORD_W-1:0] in_cell_x,
  input  logic [tds_pkg::IN_COORD_W-1:0] in_cell_y,
  input  logic [tds_pkg::LEVEL_W-1:0]   in_level_in,
  input  logic [tds_pkg::DIM_W-1:0]     eff_w,
  input  logic [tds_pkg::DIM_W-1:0]     eff_h,
  output logic                          q_push,
  output tds_pkg::item_t                q_item,
  input  logic                          q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                        st_r, st_nxt;
  logic [2:0]                     cnt_r, cnt_nxt;
  logic                           cmd_r, cmd_nxt;
  logic [tds_pkg::IN_COORD_W-1:0] raw_x_r, raw_x_nxt;
  logic [tds_pkg::IN_COORD_W-1:0] raw_y_r, raw_y_nxt;
  logic [tds_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic [tds_pkg::COORD_W-1:0]    rem_x_r, rem_x_nxt;
  logic [tds_pkg::COORD_W-1:0]    rem_y_r, rem_y_nxt;

  logic                           accept;
  logic [tds_pkg::COORD_W:0]      sx, sy, rx, ry;
  logic [tds_pkg::COORD_W:0]      x_inc, y_inc;

  always_comb begin
    // one remainder bit per cycle, both coordinates together
    sx = {rem_x_r, raw_x_r[cnt_r]};
    sy = {rem_y_r, raw_y_r[cnt_r]};
    rx = (sx >= {1'b0, eff_w}) ? sx - {1'b0, eff_w} : sx;
    ry = (sy >= {1'b0, eff_h}) ? sy - {1'b0, eff_h} : sy;

    x_inc = {1'b0, rem_x_r} + 9'd1;
    y_inc = {1'b0, rem_y_r} + 9'd1;

    q_item.cmd   = cmd_r;
    q_item.x     = rem_x_r;
    q_item.y     = rem_y_r;
    q_item.xl    = (rem_x_r == '0) ? eff_w - 8'd1 : rem_x_r - 8'd1;
    q_item.xr    = (x_inc == {1'b0, eff_w}) ? '0 : x_inc[tds_pkg::COORD_W-1:0];
    q_item.yu    = (rem_y_r == '0) ? eff_h - 8'd1 : rem_y_r - 8'd1;
    q_item.yd    = (y_inc == {1'b0, eff_h}) ? '0 : y_inc[tds_pkg::COORD_W-1:0];
    q_item.level = level_r;

    q_push = (st_r == F_PUSH) && !q_full;
    full   = !((st_r == F_IDLE) || q_push);
    accept = push && !full;
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    raw_x_nxt = raw_x_r;
    raw_y_nxt = raw_y_r;
    level_nxt = level_r;
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;

    case (st_r)
      F_IDLE, F_PUSH: begin
        if (st_r == F_PUSH && q_push) begin
          st_nxt = F_IDLE;
        end
        if (accept) begin
          st_nxt    = F_MOD;
          cnt_nxt   = 3'(tds_pkg::IN_COORD_W - 1);
          cmd_nxt   = in_command;
          raw_x_nxt = in_cell_x;
          raw_y_nxt = in_cell_y;
          level_nxt = in_level_in;
          rem_x_nxt = '0;
          rem_y_nxt = '0;
        end
      end
      F_MOD: begin
        rem_x_nxt = rx[tds_pkg::COORD_W-1:0];
        rem_y_nxt = ry[tds_pkg::COORD_W-1:0];
        cnt_nxt   = cnt_r - 3'd1;
        if (cnt_r == '0) begin
          st_nxt = F_PUSH;
        end
      end
      default: begin
        st_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    cmd_r   <= cmd_nxt;
    raw_x_r <= raw_x_nxt;
    raw_y_r <= raw_y_nxt;
    level_r <= level_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
  end

endmodule

`default_nettype wire

### rtl/tds_queue.sv
// ----------------------------------------------------------------------------
// tds_queue
// short item queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module tds_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tds_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output tds_pkg::item_t rd_item,
  output logic           empty
);

  localparam int PTR_W = (tds_pkg::QUEUE_DEPTH > 1) ? $clog2(tds_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tds_pkg::QUEUE_DEPTH + 1);

  tds_pkg::item_t   mem_r [0:tds_pkg::QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full    = (count_r == CNT_W'(tds_pkg::QUEUE_DEPTH));
    empty   = (count_r == '0);
    rd_item = mem_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && !empty;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

### rtl/tds_back.sv
// ----------------------------------------------------------------------------
// tds_back
// grid stores, nine-cell gather, mean, blends, clamp and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tds_back #(
  parameter int MAX_WIDTH = 128,
  parameter int ADDR_W    = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tds_pkg::item_t                  q_item,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic [tds_pkg::RATE_W-1:0]      diffusion_rate,
  input  logic [tds_pkg::RATE_W-1:0]      regrowth_rate,
  input  logic [tds_pkg::LEVEL_W-1:0]     nutrient_max,
  output logic                            ram_en,
  output logic                            ram_we,
  output logic [ADDR_W-1:0]               ram_addr,
  output logic [tds_pkg::LEVEL_W-1:0]     ram_wdata,
  input  logic [tds_pkg::LEVEL_W-1:0]     ram_rdata,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [tds_pkg::OUT_COORD_W-1:0] out_x,
  output logic [tds_pkg::OUT_COORD_W-1:0] out_y,
  output logic [tds_pkg::LEVEL_W-1:0]     out_level
);

  localparam int LW = tds_pkg::LEVEL_W;
  localparam int PW = 2 * LW + 2;

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_READ  = 11'b00000000010,
    B_DRAIN = 11'b00000000100,
    B_MEAN  = 11'b00000001000,
    B_DIFF1 = 11'b00000010000,
    B_MUL1  = 11'b00000100000,
    B_ADD1  = 11'b00001000000,
    B_DIFF2 = 11'b00010000000,
    B_MUL2  = 11'b00100000000,
    B_ADD2  = 11'b01000000000,
    B_OUT   = 11'b10000000000
  } bstate_t;

  bstate_t                          st_r, st_nxt;
  tds_pkg::item_t                   cur_r, cur_nxt;
  logic [tds_pkg::NBR_IDX_W-1:0]    k_r, k_nxt;
  logic                             rd_pend_r, first_r;
  logic [tds_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [LW-1:0]                    base_r, base_nxt;
  logic [2*tds_pkg::SUM_W-1:0]      recip_r, recip_nxt;
  logic signed [LW:0]               diff_r, diff_nxt;
  logic signed [PW-1:0]             bprod_r, bprod_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [tds_pkg::OUT_COORD_W-1:0]  out_x_r, out_x_nxt;
  logic [tds_pkg::OUT_COORD_W-1:0]  out_y_r, out_y_nxt;
  logic [LW-1:0]                    out_level_r, out_level_nxt;

  logic [tds_pkg::COORD_W-1:0]      xs, ys;
  logic [31:0]                      addr_wide;
  logic                             idle_store;
  logic                             out_free;
  logic [LW-1:0]                    mean;
  logic [tds_pkg::RATE_W-1:0]       mul_rate;
  logic signed [PW-1:0]             num;

  always_comb begin
    case (tds_pkg::NBR_XSEL[k_r])
      tds_pkg::SEL_LO: xs = cur_r.xl;
      tds_pkg::SEL_HI: xs = cur_r.xr;
      default:         xs = cur_r.x;
    endcase
    case (tds_pkg::NBR_YSEL[k_r])
      tds_pkg::SEL_LO: ys = cur_r.yu;
      tds_pkg::SEL_HI: ys = cur_r.yd;
      default:         ys = cur_r.y;
    endcase

    idle_store = (st_r == B_IDLE) && !q_empty && (q_item.cmd == tds_pkg::CMD_STORE);
    if (st_r == B_IDLE) begin
      xs = q_item.x;
      ys = q_item.y;
    end
    addr_wide = 32'(ys) * 32'(MAX_WIDTH) + 32'(xs);

    ram_addr  = addr_wide[ADDR_W-1:0];
    ram_en    = idle_store || (st_r == B_READ);
    ram_we    = idle_store;
    ram_wdata = q_item.level;
    q_pop     = (st_r == B_IDLE) && !q_empty;

    out_empty = !out_valid_r;
    out_x     = out_x_r;
    out_y     = out_y_r;
    out_level = out_level_r;
    out_free  = !out_valid_r || out_pop;

    mean     = recip_r[tds_pkg::RECIP_SHIFT +: LW];
    mul_rate = (st_r == B_MUL2) ? regrowth_rate : diffusion_rate;
    // base*65536 + rate*(target-base) + half, never negative
    num      = $signed({2'b00, base_r, {LW{1'b0}}}) + bprod_r
               + $signed(PW'(32'd32768));
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    base_nxt      = base_r;
    recip_nxt     = recip_r;
    diff_nxt      = diff_r;
    bprod_nxt     = bprod_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_level_nxt = out_level_r;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    // gather: data of the previous read arrives now
    if (rd_pend_r) begin
      sum_nxt = sum_r + tds_pkg::SUM_W'(ram_rdata);
      if (first_r) begin
        base_nxt = ram_rdata;
      end
    end

    case (st_r)
      B_IDLE: begin
        if (!q_empty && q_item.cmd == tds_pkg::CMD_COMPUTE) begin
          cur_nxt = q_item;
          k_nxt   = '0;
          sum_nxt = '0;
          st_nxt  = B_READ;
        end
      end
      B_READ: begin
        k_nxt = k_r + 1'b1;
        if (k_r == tds_pkg::NBR_IDX_W'(tds_pkg::NBR_COUNT - 1)) begin
          st_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        st_nxt = B_MEAN;
      end
      B_MEAN: begin
        recip_nxt = (sum_r + tds_pkg::SUM_W'(4)) * tds_pkg::RECIP_NINE;
        st_nxt    = B_DIFF1;
      end
      B_DIFF1: begin
        diff_nxt = $signed({1'b0, mean}) - $signed({1'b0, base_r});
        st_nxt   = B_MUL1;
      end
      B_MUL1, B_MUL2: begin
        bprod_nxt = PW'($signed({1'b0, mul_rate}) * diff_r);
        st_nxt    = (st_r == B_MUL1) ? B_ADD1 : B_ADD2;
      end
      B_ADD1, B_ADD2: begin
        base_nxt = num[2*LW-1:LW];
        st_nxt   = (st_r == B_ADD1) ? B_DIFF2 : B_OUT;
      end
      B_DIFF2: begin
        diff_nxt = $signed({1'b0, nutrient_max}) - $signed({1'b0, base_r});
        st_nxt   = B_MUL2;
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = cur_r.x[tds_pkg::OUT_COORD_W-1:0];
          out_y_nxt     = cur_r.y[tds_pkg::OUT_COORD_W-1:0];
          out_level_nxt = (base_r > nutrient_max) ? nutrient_max : base_r;
          st_nxt        = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      rd_pend_r   <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_pend_r   <= (st_r == B_READ);
      first_r     <= (st_r == B_READ) && (k_r == '0);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    k_r         <= k_nxt;
    sum_r       <= sum_nxt;
    base_r      <= base_nxt;
    recip_r     <= recip_nxt;
    diff_r      <= diff_nxt;
    bprod_r     <= bprod_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_level_r <= out_level_nxt;
  end

endmodule

`default_nettype wire

### tb/toroidal_diffusion_stencil_core_tb.sv
// ----------------------------------------------------------------------------
// toroidal_diffusion_stencil_core_tb
// self-checking bench for the wrap-around nutrient diffusion stencil
//
// a local copy of the grid and registers predicts each diffused level as
// compute beats are accepted. the result checker compares every popped beat
// with the oldest prediction. directed tests cover corner wrap, degenerate
// and saturated grid sizes, rate and clamp extremes and writes to unmapped
// register indexes. random phases then reconfigure the block and mix stores
// with computes whose neighbourhood has always been written first.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_diffusion_stencil_core_tb;
  import tds_pkg::*;

  localparam int GRID_W        = 128;
  localparam int GRID_H        = 128;
  localparam int GRID_CELLS    = GRID_W * GRID_H;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  typedef enum int {POP_EVERY, POP_COIN, POP_SPARSE, POP_MOSTLY} pop_pattern_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] x;
    logic [OUT_COORD_W-1:0] y;
    logic [LEVEL_W-1:0]     level;
  } diffused_cell_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic                   in_command = CMD_STORE;
  logic [IN_COORD_W-1:0]  in_cell_x = '0;
  logic [IN_COORD_W-1:0]  in_cell_y = '0;
  logic [LEVEL_W-1:0]     in_level_in = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [OUT_COORD_W-1:0] out_x;
  logic [OUT_COORD_W-1:0] out_y;
  logic [LEVEL_W-1:0]     out_level_out;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // local copy of the grid and of the register file
  diffused_cell_t     expected_levels[$];
  logic [LEVEL_W-1:0] grid_copy [0:GRID_CELLS-1];
  bit                 cell_stored [0:GRID_CELLS-1];
  int                 stored_cells[$];
  logic [DIM_W-1:0]   width_reg = 8'd128;
  logic [DIM_W-1:0]   height_reg = 8'd128;
  logic [RATE_W-1:0]  diffusion_reg = 16'd16384;
  logic [RATE_W-1:0]  regrowth_reg = 16'd0;
  logic [LEVEL_W-1:0] max_reg = 16'hFFFF;

  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int computes_sent = 0;
  int settings_used = 1;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_span = 0;
  pop_pattern_t pop_pattern = POP_EVERY;

  toroidal_diffusion_stencil_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_level_in   (in_level_in),
    .empty         (empty),
    .pop           (pop),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_level_out (out_level_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic int usable_dim(input logic [DIM_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  // move a toward b by a q0.16 fraction, rounded to nearest
  function automatic logic [LEVEL_W-1:0] blend_q16(input longint unsigned a,
                                                   input longint unsigned b,
                                                   input longint unsigned rate);
    longint unsigned num;
    if (b >= a) num = (a << 16) + rate * (b - a);
    else num = (a << 16) - rate * (a - b);
    return LEVEL_W'((num + 32768) >> 16);
  endfunction

  function automatic diffused_cell_t diffuse_cell(input int cx, input int cy);
    int w, h;
    int xs[3];
    int ys[3];
    longint unsigned total;
    longint unsigned centre;
    logic [LEVEL_W-1:0] toward_mean;
    logic [LEVEL_W-1:0] regrown;
    diffused_cell_t r;
    w = usable_dim(width_reg, GRID_W);
    h = usable_dim(height_reg, GRID_H);
    xs[0] = cx;
    xs[1] = (cx == 0) ? w - 1 : cx - 1;
    xs[2] = (cx + 1 == w) ? 0 : cx + 1;
    ys[0] = cy;
    ys[1] = (cy == 0) ? h - 1 : cy - 1;
    ys[2] = (cy + 1 == h) ? 0 : cy + 1;
    total = 0;
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++)
        total += 64'(grid_copy[ys[j] * GRID_W + xs[i]]);
    centre = 64'(grid_copy[cy * GRID_W + cx]);
    toward_mean = blend_q16(centre, (total + 4) / 9, 64'(diffusion_reg));
    regrown = blend_q16(64'(toward_mean), 64'(max_reg), 64'(regrowth_reg));
    if (regrown > max_reg) regrown = max_reg;
    r.x = OUT_COORD_W'(cx);
    r.y = OUT_COORD_W'(cy);
    r.level = regrown;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return LEVEL_W'(16'hFFFF - $urandom_range(0, 255));
      3: return LEVEL_W'($urandom_range(0, 255));
      default: return LEVEL_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom_range(0, 1023));
      default: return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // low byte is the size, high byte is junk the register must drop
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    logic [DIM_W-1:0] d;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = DIM_W'(GRID_W);
      2: d = DIM_W'($urandom_range(GRID_W + 1, 255));
      3: d = DIM_W'($urandom_range(9, GRID_W - 1));
      default: d = DIM_W'($urandom_range(1, 8));
    endcase
    return {8'($urandom_range(0, 255)), d};
  endfunction

  // one input beat; bursts of random length with random gaps in between
  task automatic send_item(input logic cmd, input int raw_x, input int raw_y,
                           input logic [LEVEL_W-1:0] level);
    int gap, cx, cy, idx;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    push        <= 1'b1;
    in_command  <= cmd;
    in_cell_x   <= IN_COORD_W'(raw_x);
    in_cell_y   <= IN_COORD_W'(raw_y);
    in_level_in <= level;
    do @(posedge clk); while (full);
    items_sent++;
    cx = raw_x % usable_dim(width_reg, GRID_W);
    cy = raw_y % usable_dim(height_reg, GRID_H);
    idx = cy * GRID_W + cx;
    if (cmd == CMD_STORE) begin
      if (!cell_stored[idx]) begin
        cell_stored[idx] = 1'b1;
        stored_cells.push_back(idx);
      end
      grid_copy[idx] = level;
    end else begin
      expected_levels.push_back(diffuse_cell(cx, cy));
      computes_sent++;
    end
  endtask

  // stores may still sit in the block after the last result, hence the settle
  task automatic drain_and_settle();
    push <= 1'b0;
    burst_left = 0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:     width_reg = data[DIM_W-1:0];
      REG_GRID_HEIGHT:    height_reg = data[DIM_W-1:0];
      REG_DIFFUSION_RATE: diffusion_reg = data;
      REG_REGROWTH_RATE:  regrowth_reg = data;
      REG_NUTRIENT_MAX:   max_reg = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] diff,
                              input logic [CFG_DATA_W-1:0] regrow,
                              input logic [CFG_DATA_W-1:0] cap, input bit stray);
    cfg_beat(REG_GRID_WIDTH, w);
    cfg_beat(REG_GRID_HEIGHT, h);
    cfg_beat(REG_DIFFUSION_RATE, diff);
    cfg_beat(REG_REGROWTH_RATE, regrow);
    cfg_beat(REG_NUTRIENT_MAX, cap);
    // indexes past the last register must be dropped
    if (stray)
      for (int i = REG_NUTRIENT_MAX + 1; i < 2 ** CFG_IDX_W; i++)
        cfg_beat(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // store every cell of the neighbourhood that has never been written
  task automatic fill_neighbourhood(input int raw_x, input int raw_y);
    int w, h, cx, cy, nx, ny;
    w = usable_dim(width_reg, GRID_W);
    h = usable_dim(height_reg, GRID_H);
    cx = raw_x % w;
    cy = raw_y % h;
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++) begin
        nx = (cx + dx + w) % w;
        ny = (cy + dy + h) % h;
        if (!cell_stored[ny * GRID_W + nx])
          send_item(CMD_STORE, nx + w * $urandom_range(0, (GRID_W - 1 - nx) / w),
                    ny + h * $urandom_range(0, (GRID_H - 1 - ny) / h), pick_level());
      end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_default_wrap_corner();
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        send_item(CMD_STORE, (dx + GRID_W) % GRID_W, (dy + GRID_H) % GRID_H,
                  (dx == 0 && dy == 0) ? 16'h0000 : 16'hFFFF);
    send_item(CMD_COMPUTE, 0, 0, 16'hFFFF);
  endtask

  task automatic test_degenerate_sizes();
    // one by one grid: the centre is its own neighbour eight times
    drain_and_settle();
    apply_config(16'h0001, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_item(CMD_STORE, GRID_W - 1, GRID_H - 1, 16'h8001);
    send_item(CMD_COMPUTE, 93, 6, 16'h0000);
    // zero sizes act as one
    drain_and_settle();
    apply_config(16'hAB00, 16'h5500, 16'd40000, 16'd30000, 16'hFFFF, 1'b0);
    send_item(CMD_COMPUTE, GRID_W - 1, 0, 16'h7FFF);
    // oversized settings saturate at the grid size
    drain_and_settle();
    apply_config(16'h00FF, 16'h00C8, 16'h8000, 16'h0100, 16'hFFFF, 1'b0);
    send_item(CMD_COMPUTE, 0, 0, 16'h0000);
    // upper data bits ignored: two columns, three rows
    drain_and_settle();
    apply_config(16'h0102, 16'hFF03, 16'h4000, 16'h0000, 16'hFFFF, 1'b0);
    send_item(CMD_STORE, 126, 125, 16'h0001);
    send_item(CMD_STORE, 127, 41, 16'hFFFE);
    send_item(CMD_COMPUTE, 1, 2, 16'h1234);
    send_item(CMD_COMPUTE, 0, 1, 16'h4321);
  endtask

  task automatic test_rate_extremes();
    // full regrowth and a cap below some of the stored levels
    drain_and_settle();
    apply_config(16'h0002, 16'h0003, 16'h0000, 16'hFFFF, 16'h1234, 1'b0);
    send_item(CMD_COMPUTE, 1, 1, 16'h0000);
    // everything clamps to a zero cap
    drain_and_settle();
    apply_config(16'h0002, 16'h0003, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_item(CMD_COMPUTE, 1, 0, 16'hFFFF);
    // both rates zero leave the centre as it was
    drain_and_settle();
    apply_config(16'h0002, 16'h0003, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_item(CMD_COMPUTE, 64, 63, 16'h0000);
  endtask

  task automatic test_unused_index();
    drain_and_settle();
    apply_config(16'h0002, 16'h0003, 16'h2000, 16'h1000, 16'hF000, 1'b1);
    send_item(CMD_COMPUTE, 1, 2, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int first, phase_end, raw_x, raw_y, idx;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      drain_and_settle();
      apply_config(pick_dim(), pick_dim(), pick_rate(), pick_rate(), pick_level(),
                   $urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(60, 200);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 6) begin
          // half the time around cells already stored, so neighbourhoods overlap
          if (stored_cells.size() != 0 && $urandom_range(0, 1) == 0) begin
            idx = stored_cells[$urandom_range(0, stored_cells.size() - 1)];
            raw_x = idx % GRID_W;
            raw_y = idx / GRID_W;
          end else begin
            raw_x = $urandom_range(0, GRID_W - 1);
            raw_y = $urandom_range(0, GRID_H - 1);
          end
          fill_neighbourhood(raw_x, raw_y);
          send_item(CMD_COMPUTE, raw_x, raw_y, LEVEL_W'($urandom_range(0, 16'hFFFF)));
        end else begin
          send_item(CMD_STORE, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                    pick_level());
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (stall_span == 0) begin
      pop_pattern = pop_pattern_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    case (pop_pattern)
      POP_EVERY:  pop <= 1'b1;
      POP_COIN:   pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    diffused_cell_t want;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        log_mismatch($sformatf("unexpected beat x=%0d y=%0d level=%h",
                               out_x, out_y, out_level_out));
      end else begin
        want = expected_levels.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_level_out !== want.level)
          log_mismatch($sformatf("expected x=%0d y=%0d level=%h, got x=%0d y=%0d level=%h",
                                 want.x, want.y, want.level, out_x, out_y, out_level_out));
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_wrap_corner();
    test_degenerate_sizes();
    test_rate_extremes();
    test_unused_index();
    test_random_traffic();
    drain_and_settle();
    $display("covered %0d input beats (%0d computes) over %0d register settings",
             items_sent, computes_sent, settings_used);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/tds_pkg.sv
rtl/tds_ram.sv
rtl/tds_front.sv
rtl/tds_queue.sv
rtl/tds_back.sv
rtl/toroidal_diffusion_stencil_core.sv
tb/toroidal_diffusion_stencil_core_tb.sv
